// ----- sv/ccart_pkg.sv -----
`timescale 1ns / 1ps
// ccart_pkg: shared types, angle constants and elaboration-time table builders
// for the cylindrical to Cartesian converter. No dependencies.
package ccart_pkg;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} coord_t;

	localparam logic signed [63:0] PI_Q58      = 64'sh0C90FDAA22168C23;
	localparam logic signed [63:0] HALF_PI_Q58 = 64'sh06487ED5110B4612;
	localparam logic signed [63:0] TWO_PI_Q58  = 64'sh1921FB54442D1847;
	localparam logic [63:0]        QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

	// Restoring shift-subtract divide, used only for constants.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q.62 by series.
	function automatic logic [63:0] atan_q62(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		int m;
		acc = '0;
		if (i == 0)
			return QUARTER_PI_Q62;
		for (int k = 0; k < 32; k++) begin
			m = i * (2 * k + 1);
			if (m <= 62) begin
				term = udiv64(64'd1 << (62 - m), 64'(2 * k + 1));
				if ((k % 2) == 0)
					acc = acc + term;
				else
					acc = acc - term;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bitv;
		n    = n_in;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bitv > n)
				bitv = bitv >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bitv != 0) begin
				if (n >= res + bitv) begin
					n   = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// CORDIC gain K in Q.30 for a given iteration count.
	function automatic logic [63:0] gain_q30(input int steps);
		logic [63:0] v;
		v = 64'd1 << 61;
		for (int i = 1; i <= 31; i++) begin
			if (i < steps)
				v = v - udiv64(v, (64'd1 << (2 * i)) + 64'd1);
		end
		return isqrt64(v >> 2);
	endfunction

endpackage

// ----- sv/cylindrical_to_cartesian.sv -----
`timescale 1ns / 1ps
// cylindrical_to_cartesian: top level, pipelined CORDIC polar to Cartesian
// conversion. Depends on ccart_pkg, ccart_reduce, ccart_stage, ccart_finish.
//
//   channel   handshake          payload
//   ------    ---------          -------
//   input     start & !busy      coord_x, coord_y, coord_z
//   result    done (1 cycle)     out_x, out_y, out_z, saturated
//   config    cfg_we             cfg_wdata (axis_select)
//
// The pipeline has three front-end stages, one stage per CORDIC step and one
// output stage. One word is taken every cycle; busy stays low.
// Reset clears all valid bits and sets axis_select to the z axis.
// The receiver cannot stall, so the pipeline never holds.
module cylindrical_to_cartesian #(
	parameter int CORDIC_STEPS = 24,
	parameter int DATA_BITS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated
);
	import ccart_pkg::*;

	localparam int LAT = 3 + CORDIC_STEPS;

	logic [1:0] axis_q;
	coord_t     in_coord;
	coord_t     raw_d [0:LAT];

	logic                        v_c [0:CORDIC_STEPS];
	logic signed [63:0]          x_c [0:CORDIC_STEPS];
	logic signed [63:0]          y_c [0:CORDIC_STEPS];
	logic signed [DATA_BITS-1:0] z_c [0:CORDIC_STEPS];

	assign busy     = 1'b0;
	assign in_coord = '{x: coord_x, y: coord_y, z: coord_z};
	assign raw_d[0] = in_coord;
	assign y_c[0]   = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			axis_q <= AXIS_Z;
		else if (cfg_we)
			axis_q <= cfg_wdata;
	end

	for (genvar g = 0; g < LAT; g++) begin : g_raw
		always_ff @(posedge clk)
			raw_d[g+1] <= raw_d[g];
	end

	ccart_reduce #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.DATA_BITS   (DATA_BITS)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.in_coord (in_coord),
		.axis     (axis_q),
		.out_valid(v_c[0]),
		.out_vx   (x_c[0]),
		.out_z    (z_c[0])
	);

	for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
		ccart_stage #(
			.DATA_BITS(DATA_BITS),
			.STEP     (s)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[s]),
			.in_x     (x_c[s]),
			.in_y     (y_c[s]),
			.in_z     (z_c[s]),
			.out_valid(v_c[s+1]),
			.out_x    (x_c[s+1]),
			.out_y    (y_c[s+1]),
			.out_z    (z_c[s+1])
		);
	end

	ccart_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c[CORDIC_STEPS]),
		.in_vx    (x_c[CORDIC_STEPS]),
		.in_vy    (y_c[CORDIC_STEPS]),
		.raw      (raw_d[LAT]),
		.axis     (axis_q),
		.done     (done),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.saturated(saturated)
	);

endmodule

// ----- sv/ccart_reduce.sv -----
`timescale 1ns / 1ps
// ccart_reduce: three-stage front end: slot select and 2*pi wrap, pi fold,
// angle rounding and radius-times-gain multiply. Depends on ccart_pkg.
module ccart_reduce #(
	parameter int CORDIC_STEPS = 24,
	parameter int DATA_BITS    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ccart_pkg::coord_t           in_coord,
	input  logic [1:0]                  axis,
	output logic                        out_valid,
	output logic signed [63:0]          out_vx,
	output logic signed [DATA_BITS-1:0] out_z
);
	import ccart_pkg::*;

	localparam int IN_SHIFT = 61 - DATA_BITS;
	localparam logic signed [63:0] IN_HALF = 64'sd1 <<< (IN_SHIFT - 1);
	localparam logic [29:0] GAIN = 30'(gain_q30(CORDIC_STEPS));

	logic               v_s1, v_s2;
	logic signed [31:0] r_s1;
	logic signed [63:0] t_s1, t_s2;
	logic signed [32:0] r_s2;

	logic signed [31:0] r_sel, th_sel;
	logic signed [63:0] t_raw, t_wrap, t_fold, t_rnd;
	logic               neg;
	logic signed [64:0] prod;

	always_comb begin
		unique case (axis)
			AXIS_X: begin
				r_sel  = in_coord.y;
				th_sel = in_coord.z;
			end
			AXIS_Y: begin
				r_sel  = in_coord.z;
				th_sel = in_coord.x;
			end
			default: begin
				r_sel  = in_coord.x;
				th_sel = in_coord.y;
			end
		endcase
		t_raw = {{2{th_sel[31]}}, th_sel, 30'b0};
		if (t_raw > PI_Q58)
			t_wrap = t_raw - TWO_PI_Q58;
		else if (t_raw < -PI_Q58)
			t_wrap = t_raw + TWO_PI_Q58;
		else
			t_wrap = t_raw;
	end

	always_comb begin
		neg = 1'b0;
		if (t_s1 > HALF_PI_Q58) begin
			t_fold = t_s1 - PI_Q58;
			neg    = 1'b1;
		end else if (t_s1 < -HALF_PI_Q58) begin
			t_fold = t_s1 + PI_Q58;
			neg    = 1'b1;
		end else begin
			t_fold = t_s1;
		end
	end

	assign t_rnd = (t_s2 + IN_HALF) >>> IN_SHIFT;
	assign prod  = r_s2 * $signed({2'b00, GAIN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= r_sel;
		t_s1   <= t_wrap;
		r_s2   <= neg ? -{r_s1[31], r_s1} : {r_s1[31], r_s1};
		t_s2   <= t_fold;
		out_z  <= t_rnd[DATA_BITS-1:0];
		out_vx <= prod[63:0];
	end

endmodule

// ----- sv/ccart_stage.sv -----
`timescale 1ns / 1ps
// ccart_stage: one registered CORDIC rotation step with its arctangent
// constant. Depends on ccart_pkg.
module ccart_stage #(
	parameter int DATA_BITS = 32,
	parameter int STEP      = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [63:0]          in_x,
	input  logic signed [63:0]          in_y,
	input  logic signed [DATA_BITS-1:0] in_z,
	output logic                        out_valid,
	output logic signed [63:0]          out_x,
	output logic signed [63:0]          out_y,
	output logic signed [DATA_BITS-1:0] out_z
);
	import ccart_pkg::*;

	localparam int ROM_SHIFT = 65 - DATA_BITS;
	localparam logic [63:0] ATAN_Q62 = atan_q62(STEP);
	localparam logic [63:0] ATAN_RND = (ATAN_Q62 + (64'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
	localparam logic signed [DATA_BITS-1:0] ATAN = ATAN_RND[DATA_BITS-1:0];

	logic signed [63:0] dx, dy;

	assign dx = in_y >>> STEP;
	assign dy = in_x >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_z[DATA_BITS-1]) begin
			out_x <= in_x - dx;
			out_y <= in_y + dy;
			out_z <= in_z - ATAN;
		end else begin
			out_x <= in_x + dx;
			out_y <= in_y - dy;
			out_z <= in_z + ATAN;
		end
	end

endmodule

// ----- sv/ccart_finish.sv -----
`timescale 1ns / 1ps
// ccart_finish: rounds Q.46 results to Q16.16, saturates and places them in
// their slots, with bypass for the unused axis code. Depends on ccart_pkg.
module ccart_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [63:0] in_vx,
	input  logic signed [63:0] in_vy,
	input  ccart_pkg::coord_t  raw,
	input  logic [1:0]         axis,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated
);
	import ccart_pkg::*;

	localparam logic signed [63:0] RND  = 64'sd1 <<< 29;
	localparam logic signed [63:0] QMAX = 64'sh000000007FFFFFFF;
	localparam logic signed [63:0] QMIN = -64'sh0000000080000000;

	logic signed [63:0] qx, qy;
	logic signed [31:0] cx, cy;
	logic               sx, sy;
	coord_t             res;
	logic               res_sat;

	assign qx = (in_vx + RND) >>> 30;
	assign qy = (in_vy + RND) >>> 30;

	always_comb begin
		sx = 1'b1;
		sy = 1'b1;
		if (qx > QMAX)
			cx = 32'sh7FFFFFFF;
		else if (qx < QMIN)
			cx = 32'sh80000000;
		else begin
			cx = qx[31:0];
			sx = 1'b0;
		end
		if (qy > QMAX)
			cy = 32'sh7FFFFFFF;
		else if (qy < QMIN)
			cy = 32'sh80000000;
		else begin
			cy = qy[31:0];
			sy = 1'b0;
		end
		res     = raw;
		res_sat = sx | sy;
		unique case (axis)
			AXIS_X: begin
				res.y = cx;
				res.z = cy;
			end
			AXIS_Y: begin
				res.z = cx;
				res.x = cy;
			end
			AXIS_Z: begin
				res.x = cx;
				res.y = cy;
			end
			default: res_sat = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_x     <= res.x;
		out_y     <= res.y;
		out_z     <= res.z;
		saturated <= res_sat;
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for cylindrical_to_cartesian; a bit-exact CORDIC model
// predicts converted points, typed rows give their own. Directed table first, then random phases per axis.
// Depends on ccart_pkg and cylindrical_to_cartesian.
module tb_top;
	import ccart_pkg::*;

	localparam int CORDIC_STEPS = 24;
	localparam int LATENCY = CORDIC_STEPS + 4;
	localparam int RANDOM_ITEMS = 550;
	localparam int CALM_TAIL = 80;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam longint PI_Q58 = 64'sh0C90FDAA22168C23;
	localparam longint HALF_PI_Q58 = 64'sh06487ED5110B4612;
	localparam longint TWO_PI_Q58 = 64'sh1921FB54442D1847;
	localparam longint unsigned QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
	localparam int PI_Q28 = 843314857;
	localparam int HALF_PI_Q28 = 421657428;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic sat;
	} cart_word_t;

	typedef struct packed {
		logic [1:0] axis;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic typed;
		cart_word_t res;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic signed [31:0] coord_z = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic busy;
	logic done;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic saturated;

	longint atan_tab [CORDIC_STEPS];
	longint gain_q30;
	logic [1:0] axis_cfg = AXIS_Z;
	cart_word_t expected_points [$];
	point_row_t dir_rows [$];
	int mismatch_count = 0;

	cylindrical_to_cartesian dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.saturated(saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("tb_top failed");
		$finish;
	end

	// {clip, value}: round Q.46 half up to Q.16 and clamp to 32 bits
	function automatic logic [32:0] round_q16(longint v);
		longint q;
		q = (v + 64'sh20000000) >>> 30;
		if (q > 64'sh7FFFFFFF)
			return {1'b1, 32'h7FFFFFFF};
		if (q < -64'sh80000000)
			return {1'b1, 32'h80000000};
		return {1'b0, q[31:0]};
	endfunction

	function automatic cart_word_t convert_point(logic [1:0] axis, logic signed [31:0] cx,
			logic signed [31:0] cy, logic signed [31:0] cz);
		logic signed [31:0] slot [0:2];
		longint r, t, ang, vx, vy, dx, dy;
		logic [32:0] rx, ry;
		int ri, ti;
		slot[0] = cx;
		slot[1] = cy;
		slot[2] = cz;
		if (axis == AXIS_NONE)
			return {cx, cy, cz, 1'b0};
		case (axis)
		AXIS_X: begin
			ri = 1;
			ti = 2;
		end
		AXIS_Y: begin
			ri = 2;
			ti = 0;
		end
		default: begin
			ri = 0;
			ti = 1;
		end
		endcase
		r = slot[ri];
		t = longint'(slot[ti]) <<< 30;
		if (t > PI_Q58)
			t -= TWO_PI_Q58;
		else if (t < -PI_Q58)
			t += TWO_PI_Q58;
		// fold into [-pi/2, pi/2] by flipping the radius
		if (t > HALF_PI_Q58) begin
			t -= PI_Q58;
			r = -r;
		end else if (t < -HALF_PI_Q58) begin
			t += PI_Q58;
			r = -r;
		end
		ang = (t + 64'sh10000000) >>> 29;
		vx = r * gain_q30;
		vy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (ang >= 0) begin
				vx -= dx;
				vy += dy;
				ang -= atan_tab[i];
			end else begin
				vx += dx;
				vy -= dy;
				ang += atan_tab[i];
			end
		end
		rx = round_q16(vx);
		ry = round_q16(vy);
		slot[ri] = rx[31:0];
		slot[ti] = ry[31:0];
		return {slot[0], slot[1], slot[2], rx[32] | ry[32]};
	endfunction

	function automatic logic [31:0] pick_word(bit angle);
		int mode;
		int base;
		mode = $urandom_range(0, 9);
		if (mode <= 2)
			return $urandom;
		if (mode == 3) begin
			case ($urandom_range(0, 4))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h00000000;
			3: return 32'h00000001;
			default: return 32'hFFFFFFFF;
			endcase
		end
		if (!angle)
			return int'($urandom_range(0, 32'h02000000)) - 32'sh01000000;
		if (mode <= 5) begin
			case ($urandom_range(0, 3))
			0: base = PI_Q28;
			1: base = -PI_Q28;
			2: base = HALF_PI_Q28;
			default: base = -HALF_PI_Q28;
			endcase
			return base + int'($urandom_range(0, 64)) - 32;
		end
		return int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
	endfunction

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	task automatic add_row(logic [1:0] axis, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] cz, logic typed, cart_word_t res);
		point_row_t row;
		row.axis = axis;
		row.cx = cx;
		row.cy = cy;
		row.cz = cz;
		row.typed = typed;
		row.res = res;
		dir_rows.push_back(row);
	endtask

	// called at a rising edge; returns at the edge that takes the word
	task automatic send_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic typed, cart_word_t typed_res);
		start <= 1'b1;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed)
			expected_points.push_back(typed_res);
		else
			expected_points.push_back(convert_point(axis_cfg, cx, cy, cz));
	endtask

	task automatic idle_burst(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic set_axis(logic [1:0] a);
		start <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		axis_cfg = a;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		cart_word_t e;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				flag_error($sformatf("unexpected word x=%h y=%h z=%h sat=%b",
					out_x, out_y, out_z, saturated));
			end else begin
				e = expected_points.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z || saturated !== e.sat)
					flag_error($sformatf(
						"expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
						e.x, e.y, e.z, e.sat, out_x, out_y, out_z, saturated));
			end
		end
	end

	initial begin
		longint unsigned acc, term, dv, kk, sq_n, sq_res, sq_bit;
		logic [31:0] r, t, o, cx, cy, cz;
		logic [1:0] a;
		int sent, n, gap_pct, wait_cycles;

		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (i == 0) begin
				acc = QUARTER_PI_Q62;
			end else begin
				acc = 0;
				for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
					dv = 64'(2 * k + 1);
					term = (64'd1 << (62 - i * (2 * k + 1))) / dv;
					if (k % 2 == 0)
						acc += term;
					else
						acc -= term;
				end
			end
			atan_tab[i] = longint'((acc + (64'd1 << 32)) >> 33);
		end
		kk = 64'd1 << 61;
		for (int i = 1; i < CORDIC_STEPS && i <= 31; i++)
			kk -= kk / ((64'd1 << (2 * i)) + 64'd1);
		sq_n = kk >> 2;
		sq_res = 0;
		sq_bit = 64'd1 << 62;
		while (sq_bit > sq_n)
			sq_bit >>= 2;
		while (sq_bit != 0) begin
			if (sq_n >= sq_res + sq_bit) begin
				sq_n -= sq_res + sq_bit;
				sq_res = (sq_res >> 1) + sq_bit;
			end else begin
				sq_res >>= 1;
			end
			sq_bit >>= 2;
		end
		gain_q30 = longint'(sq_res);

		// first rows run on the reset axis (z)
		add_row(AXIS_Z, 32'h00000000, 32'h7FFFFFFF, 32'h12345678, 1'b1,
			{32'h00000000, 32'h00000000, 32'h12345678, 1'b0});
		add_row(AXIS_Z, 32'h00010000, 32'h00000000, 32'h80000000, 1'b0, '0);
		add_row(AXIS_Z, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0);
		// most negative radius folded by pi
		add_row(AXIS_Z, 32'h80000000, 32'h3243F6A8, 32'h00000000, 1'b0, '0);
		add_row(AXIS_Z, 32'h80000000, 32'hCDBC0958, 32'hFFFFFFFF, 1'b0, '0);
		add_row(AXIS_Z, 32'h80000000, 32'h1921FB54, 32'h55555555, 1'b0, '0);
		add_row(AXIS_Z, 32'h7FFFFFFF, 32'h0C90FDAA, 32'hAAAAAAAA, 1'b0, '0);
		add_row(AXIS_X, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 1'b1,
			{32'h7FFFFFFF, 32'h00000000, 32'h00000000, 1'b0});
		add_row(AXIS_X, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0);
		add_row(AXIS_X, 32'hFFFFFFFF, 32'h80000000, 32'h3243F6A9, 1'b0, '0);
		add_row(AXIS_X, 32'h00000000, 32'h00030000, 32'hE6DE04AC, 1'b0, '0);
		add_row(AXIS_Y, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1,
			{32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b0});
		add_row(AXIS_Y, 32'h80000000, 32'h00000000, 32'h7FFFFFFF, 1'b0, '0);
		add_row(AXIS_Y, 32'h1921FB55, 32'h55555555, 32'h80000000, 1'b0, '0);
		add_row(AXIS_Y, 32'h00000001, 32'hAAAAAAAA, 32'hFFFF0000, 1'b0, '0);
		// unused axis code: straight pass-through
		add_row(AXIS_NONE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1,
			{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0});
		add_row(AXIS_NONE, 32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b1,
			{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b0});
		add_row(AXIS_NONE, 32'h55555555, 32'hAAAAAAAA, 32'h00000001, 1'b1,
			{32'h55555555, 32'hAAAAAAAA, 32'h00000001, 1'b0});
		add_row(AXIS_Z, 32'h7FFFFFFF, 32'h3243F6A8, 32'h00000000, 1'b0, '0);
		add_row(AXIS_Z, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 1'b0, '0);

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].axis != axis_cfg)
				set_axis(dir_rows[i].axis);
			idle_burst(30);
			send_point(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].cz,
				dir_rows[i].typed, dir_rows[i].res);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			n = $urandom_range(30, 80);
			if ($urandom_range(0, 7) == 0)
				a = AXIS_NONE;
			else
				a = 2'($urandom_range(0, 2));
			set_axis(a);
			case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 40;
			endcase
			for (int j = 0; j < n && sent < RANDOM_ITEMS; j++) begin
				if (RANDOM_ITEMS - sent > CALM_TAIL)
					idle_burst(gap_pct);
				r = pick_word(1'b0);
				t = pick_word(1'b1);
				o = $urandom;
				case (a)
				AXIS_X: begin
					cx = o;
					cy = r;
					cz = t;
				end
				AXIS_Y: begin
					cx = t;
					cy = o;
					cz = r;
				end
				AXIS_Z: begin
					cx = r;
					cy = t;
					cz = o;
				end
				default: begin
					cx = r;
					cy = t;
					cz = pick_word(1'b0);
				end
				endcase
				send_point(cx, cy, cz, 1'b0, '0);
				sent++;
			end
		end

		start <= 1'b0;
		wait_cycles = 0;
		while (expected_points.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4)
			@(posedge clk);
		if (expected_points.size() != 0)
			flag_error($sformatf("%0d words never arrived", expected_points.size()));
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/ccart_pkg.sv
sv/ccart_reduce.sv
sv/ccart_stage.sv
sv/ccart_finish.sv
sv/cylindrical_to_cartesian.sv
sim/tb_top.sv
